FILE: src/assert_macros.svh
// Assertion macros for the property checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/lsmc_pkg.sv
`default_nettype none

package lsmc_pkg;

   // Sizes of the matcher.
   localparam int MAX_PATTERN_BYTES = 32;
   localparam int LINE_COUNT_BITS   = 16;

   // Fixed field widths.
   localparam int BYTE_BITS      = 8;
   localparam int WORD_BITS      = 64;
   localparam int PATTERN_WORDS  = 4;
   localparam int PATTERN_BITS   = PATTERN_WORDS * WORD_BITS;
   localparam int LENGTH_BITS    = 6;
   localparam int LINE_LEN_BITS  = 16;
   localparam int ROW_BITS       = 32;
   localparam int COUNT_BITS     = 16;
   localparam int CSR_INDEX_BITS = 3;

   // Byte codes and reset values.
   localparam logic [BYTE_BITS-1:0]     NEWLINE_BYTE     = 8'h0A;
   localparam logic [BYTE_BITS-1:0]     ZERO_BYTE        = 8'h00;
   localparam logic [LINE_LEN_BITS-1:0] DEFAULT_MAX_LINE = 16'd1024;
   localparam logic [LENGTH_BITS-1:0]   DEFAULT_PATTERN_LENGTH = 6'd1;

   // Match count saturates at the smaller of the count field and LINE_COUNT_BITS.
   localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = (LINE_COUNT_BITS >= COUNT_BITS) ?
      {COUNT_BITS{1'b1}} : COUNT_BITS'((64'd1 << LINE_COUNT_BITS) - 64'd1);

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_0      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_1      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_2      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_3      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_LINE       = 3'd5;

   // Configuration as seen by the match core.
   typedef struct packed {
      logic [PATTERN_BITS-1:0]  pattern;
      logic [LENGTH_BITS-1:0]   pattern_length;
      logic [LINE_LEN_BITS-1:0] max_line_length;
   } lsmc_cfg_type;

   // Outcome of one processed item.
   typedef struct packed {
      logic                  hit;
      logic [ROW_BITS-1:0]   line_row;
      logic [COUNT_BITS-1:0] match_total;
   } lsmc_result_type;

endpackage

`default_nettype wire

FILE: src/lsmc_csr.sv
`default_nettype none

module lsmc_csr
   import lsmc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_valid,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [WORD_BITS-1:0]      csr_wdata,
   output lsmc_cfg_type                   cfg
);

   logic [WORD_BITS-1:0]     pattern_ff [PATTERN_WORDS];
   logic [WORD_BITS-1:0]     pattern_in [PATTERN_WORDS];
   logic [LENGTH_BITS-1:0]   length_ff, length_in;
   logic [LINE_LEN_BITS-1:0] max_line_ff, max_line_in;

   // Register write decode; indexes past the list are ignored.
   always_comb begin
      pattern_in  = pattern_ff;
      length_in   = length_ff;
      max_line_in = max_line_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_PATTERN_0:      pattern_in[0] = csr_wdata;
            REG_PATTERN_1:      pattern_in[1] = csr_wdata;
            REG_PATTERN_2:      pattern_in[2] = csr_wdata;
            REG_PATTERN_3:      pattern_in[3] = csr_wdata;
            REG_PATTERN_LENGTH: length_in     = csr_wdata[LENGTH_BITS-1:0];
            REG_MAX_LINE:       max_line_in   = csr_wdata[LINE_LEN_BITS-1:0];
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < PATTERN_WORDS; w++) begin
            pattern_ff[w] <= '0;
         end
         length_ff   <= DEFAULT_PATTERN_LENGTH;
         max_line_ff <= DEFAULT_MAX_LINE;
      end else begin
         pattern_ff  <= pattern_in;
         length_ff   <= length_in;
         max_line_ff <= max_line_in;
      end
   end

   // Flatten the pattern words, word 0 in the low bits.
   always_comb begin
      for (int w = 0; w < PATTERN_WORDS; w++) begin
         cfg.pattern[w*WORD_BITS +: WORD_BITS] = pattern_ff[w];
      end
      cfg.pattern_length  = length_ff;
      cfg.max_line_length = max_line_ff;
   end

endmodule

`default_nettype wire

FILE: src/lsmc_core.sv
`default_nettype none

module lsmc_core
   import lsmc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [BYTE_BITS-1:0] text_byte,
   input  wire logic                 file_start,
   input  lsmc_cfg_type              cfg,
   output lsmc_result_type           result
);

   logic [MAX_PATTERN_BYTES-1:0] vec_ff, vec_in;
   logic [ROW_BITS-1:0]          row_ff, row_in;
   logic [LINE_LEN_BITS-1:0]     bytes_ff, bytes_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic                         zero_ff, zero_in;
   logic                         abandon_ff, abandon_in;

   logic [LENGTH_BITS-1:0]       used_len;
   logic [MAX_PATTERN_BYTES-1:0] byte_hits;
   logic [MAX_PATTERN_BYTES-1:0] last_bit;
   logic [MAX_PATTERN_BYTES-1:0] shifted_vec;
   logic                         pattern_hit;

   // Pattern length saturates at the vector width.
   assign used_len = (cfg.pattern_length > LENGTH_BITS'(MAX_PATTERN_BYTES)) ?
                     LENGTH_BITS'(MAX_PATTERN_BYTES) : cfg.pattern_length;

   // Per pattern position: byte compare limited to the used length, and the end position.
   always_comb begin
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         byte_hits[i] = (cfg.pattern[i*BYTE_BITS +: BYTE_BITS] == text_byte) &&
                        (used_len > LENGTH_BITS'(i));
         last_bit[i]  = (used_len == LENGTH_BITS'(i + 1));
      end
   end

   // Shift-and step on the state as it stands after an optional file start.
   always_comb begin
      vec_in      = file_start ? '0 : vec_ff;
      row_in      = file_start ? '0 : row_ff;
      bytes_in    = file_start ? '0 : bytes_ff;
      count_in    = file_start ? '0 : count_ff;
      zero_in     = file_start ? 1'b0 : zero_ff;
      abandon_in  = file_start ? 1'b0 : abandon_ff;
      shifted_vec = {vec_in[MAX_PATTERN_BYTES-2:0], 1'b1} & byte_hits;
      pattern_hit = |(shifted_vec & last_bit);
      result.hit         = 1'b0;
      result.line_row    = row_in;
      result.match_total = count_in;

      if (abandon_in) begin
         // Rest of the file is ignored.
      end else if (bytes_in == cfg.max_line_length) begin
         abandon_in = 1'b1;
      end else if (text_byte == NEWLINE_BYTE) begin
         result.hit = (count_in != '0);
         row_in     = row_in + 1'b1;
         vec_in     = '0;
         bytes_in   = '0;
         count_in   = '0;
         zero_in    = 1'b0;
      end else begin
         bytes_in = bytes_in + 1'b1;
         if (text_byte == ZERO_BYTE || zero_in) begin
            zero_in = 1'b1;
            vec_in  = '0;
         end else begin
            vec_in = shifted_vec;
            if (pattern_hit && count_in < COUNT_LIMIT) begin
               count_in = count_in + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_ff     <= '0;
         row_ff     <= '0;
         bytes_ff   <= '0;
         count_ff   <= '0;
         zero_ff    <= 1'b0;
         abandon_ff <= 1'b0;
      end else if (step) begin
         vec_ff     <= vec_in;
         row_ff     <= row_in;
         bytes_ff   <= bytes_in;
         count_ff   <= count_in;
         zero_ff    <= zero_in;
         abandon_ff <= abandon_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/line_substring_match_counter.sv
// Flow: an accepted item goes into the input register; when it is stepped, the line
// state and the result register update together, and rsp_valid shows the result.
// Throughput: one byte per cycle while rsp_ready is high; a held result stalls the
// input register, which then holds one more byte before req_ready drops.
// Reset: synchronous, active high; clears all line state, row, abandon flag and the
// channel valids, and loads the configuration reset values.
`default_nettype none

module line_substring_match_counter
   import lsmc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [BYTE_BITS-1:0]      req_text_byte,
   input  wire logic                      req_file_start,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [ROW_BITS-1:0]            rsp_line_row,
   output logic [COUNT_BITS-1:0]          rsp_match_total,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [WORD_BITS-1:0]      csr_wdata
);

   lsmc_cfg_type    cfg;
   lsmc_result_type result;

   logic                  in_valid_ff, in_valid_in;
   logic [BYTE_BITS-1:0]  in_byte_ff;
   logic                  in_start_ff;
   logic                  out_free;
   logic                  step;
   logic                  out_valid_ff, out_valid_in;
   logic [ROW_BITS-1:0]   out_row_ff;
   logic [COUNT_BITS-1:0] out_total_ff;

   // Configuration registers take a write in every cycle.
   assign csr_ready = 1'b1;

   lsmc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The item in the input register is processed when the result register is free.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || step;

   lsmc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .text_byte  (in_byte_ff),
      .file_start (in_start_ff),
      .cfg        (cfg),
      .result     (result)
   );

   // Input register.
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff  <= req_text_byte;
         in_start_ff <= req_file_start;
      end
   end

   // Result register.
   assign out_valid_in = out_free ? (step && result.hit) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && result.hit) begin
         out_row_ff   <= result.line_row;
         out_total_ff <= result.match_total;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_line_row    = out_row_ff;
   assign rsp_match_total = out_total_ff;

endmodule

`default_nettype wire

FILE: src/lsmc_checker.sv
`default_nettype none
`include "assert_macros.svh"

module lsmc_props
   import lsmc_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic [ROW_BITS-1:0]       rsp_line_row,
   input wire logic [COUNT_BITS-1:0]     rsp_match_total
);

   // A reported line always holds at least one match.
   `ASSERT_CLK(a_total_nonzero, clock, reset, rsp_valid |-> rsp_match_total != '0, "empty line result")

   // A stalled result keeps its payload.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_line_row) && $stable(rsp_match_total), "result changed while stalled")

   // The input side stalls only behind a result that is held.
   `ASSERT_CLK(a_req_stall, clock, reset, req_valid && !req_ready |-> rsp_valid && !rsp_ready, "input stalled without a held result")

   // Reset empties the result register.
   `ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind line_substring_match_counter lsmc_props u_lsmc_props (.*);

`default_nettype wire

FILE: dv/lsmc_checker.sv
// Watches the byte, result and register channels of the matcher, predicts the
// line results from the accepted bytes and compares them with what comes out.
module lsmc_checker
   import lsmc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic                      req_ready,
   input  wire logic [BYTE_BITS-1:0]      req_text_byte,
   input  wire logic                      req_file_start,
   input  wire logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire logic [ROW_BITS-1:0]       rsp_line_row,
   input  wire logic [COUNT_BITS-1:0]     rsp_match_total,
   input  wire logic                      csr_valid,
   input  wire logic                      csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [WORD_BITS-1:0]      csr_wdata,
   output int                             mismatch_count,
   output int                             hits_waiting
);

   // One reported line: its row and how many times the pattern ended in it.
   typedef struct packed {
      logic [ROW_BITS-1:0]   row;
      logic [COUNT_BITS-1:0] total;
   } line_hit_t;

   line_hit_t hits_due[$];

   // Shadow of the configuration registers.
   logic [PATTERN_BITS-1:0]  cfg_pattern;
   logic [LENGTH_BITS-1:0]   cfg_length;
   logic [LINE_LEN_BITS-1:0] cfg_max_line;

   // Shadow of the scan state.
   logic [31:0]              shift_vec;
   logic [ROW_BITS-1:0]      cur_row;
   logic [LINE_LEN_BITS-1:0] line_len;
   logic [COUNT_BITS-1:0]    line_hits;
   logic                     zero_seen;
   logic                     file_dropped;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("lsmc_checker: %s", what);
      end
   endtask

   function automatic void clear_line();
      shift_vec = '0;
      line_len  = '0;
      line_hits = '0;
      zero_seen = 1'b0;
   endfunction

   // Advances the shadow scan by one byte and queues a line result if one is due.
   task automatic scan_byte(input logic [BYTE_BITS-1:0] c, input logic fs);
      int unsigned len;
      logic [31:0] mask;
      line_hit_t   hit;
      if (fs) begin
         clear_line();
         cur_row      = '0;
         file_dropped = 1'b0;
      end
      if (file_dropped) return;
      // A byte that finds the line already full drops the rest of the file.
      if (line_len == cfg_max_line) begin
         file_dropped = 1'b1;
         return;
      end
      if (c == NEWLINE_BYTE) begin
         if (line_hits != '0) begin
            hit.row   = cur_row;
            hit.total = line_hits;
            hits_due.push_back(hit);
         end
         cur_row = cur_row + 1'b1;
         clear_line();
         return;
      end
      line_len = line_len + 1'b1;
      // A zero byte halts matching until the end of its line.
      if (c == ZERO_BYTE) zero_seen = 1'b1;
      if (zero_seen) begin
         shift_vec = '0;
         return;
      end
      len = (cfg_length > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : cfg_length;
      if (len == 0) begin
         shift_vec = '0;
         return;
      end
      mask = '0;
      for (int i = 0; i < len; i++) begin
         if (cfg_pattern[i*BYTE_BITS +: BYTE_BITS] == c) mask[i] = 1'b1;
      end
      shift_vec = ((shift_vec << 1) | 32'd1) & mask;
      if (shift_vec[len-1] && line_hits < COUNT_LIMIT) line_hits = line_hits + 1'b1;
   endtask

   // Sample every channel at the rising edge; results are checked before new
   // bytes are scanned, since a result never comes from a byte of the same edge.
   always @(posedge clock) begin
      line_hit_t due;
      if (reset) begin
         cfg_pattern    = '0;
         cfg_length     = DEFAULT_PATTERN_LENGTH;
         cfg_max_line   = DEFAULT_MAX_LINE;
         cur_row        = '0;
         file_dropped   = 1'b0;
         mismatch_count = 0;
         clear_line();
         hits_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (hits_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result row %0d total %0d",
                                         rsp_line_row, rsp_match_total));
            end else begin
               due = hits_due.pop_front();
               if (rsp_line_row !== due.row) begin
                  report_mismatch($sformatf("line_row %0h, expected %0h",
                                            rsp_line_row, due.row));
               end
               if (rsp_match_total !== due.total) begin
                  report_mismatch($sformatf("match_total %0d on row %0d, expected %0d",
                                            rsp_match_total, due.row, due.total));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PATTERN_0: begin
                  cfg_pattern[0*WORD_BITS +: WORD_BITS] = csr_wdata;
               end
               REG_PATTERN_1: begin
                  cfg_pattern[1*WORD_BITS +: WORD_BITS] = csr_wdata;
               end
               REG_PATTERN_2: begin
                  cfg_pattern[2*WORD_BITS +: WORD_BITS] = csr_wdata;
               end
               REG_PATTERN_3: begin
                  cfg_pattern[3*WORD_BITS +: WORD_BITS] = csr_wdata;
               end
               REG_PATTERN_LENGTH: begin
                  cfg_length = csr_wdata[LENGTH_BITS-1:0];
               end
               REG_MAX_LINE: begin
                  cfg_max_line = csr_wdata[LINE_LEN_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) scan_byte(req_text_byte, req_file_start);
      end
      hits_waiting = hits_due.size();
   end

endmodule

FILE: dv/tb.sv
// Drives file bytes and register writes into the matcher; the checker beside it
// predicts and compares the line results.
module tb
   import lsmc_pkg::*;
;

   localparam int IDLE_LIMIT = 3000;
   localparam logic [CSR_INDEX_BITS-1:0] SPARE_INDEX_6 = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] SPARE_INDEX_7 = 3'd7;
   localparam logic [BYTE_BITS-1:0] LETTER_A = 8'h61;
   localparam logic [BYTE_BITS-1:0] LETTER_B = 8'h62;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [BYTE_BITS-1:0]      req_text_byte;
   logic                      req_file_start;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [ROW_BITS-1:0]       rsp_line_row;
   logic [COUNT_BITS-1:0]     rsp_match_total;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [WORD_BITS-1:0]      csr_wdata;
   int                        mismatch_count;
   int                        hits_waiting;

   // Stimulus-side copy of the pattern, written to the pattern registers and used to build lines that match.
   logic [BYTE_BITS-1:0] pat_bytes[MAX_PATTERN_BYTES];
   int unsigned          pat_use;
   logic                 steady_line;
   logic                 next_fs;
   int unsigned          bytes_sent;
   int unsigned          idle_cycles;

   line_substring_match_counter i_dut (.*);

   lsmc_checker i_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // End the run when no channel has moved an item for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: bursts of ready with short stalls, a few long ones, and
   // now and then a long stretch without any stall.
   initial begin
      int unsigned on_len;
      int unsigned off_len;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         on_len  = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                                : $urandom_range(100, 300);
         off_len = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3)
                                                : $urandom_range(20, 60);
         rsp_ready <= 1'b1;
         repeat (on_len) @(negedge clock);
         rsp_ready <= 1'b0;
         repeat (off_len) @(negedge clock);
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Mostly letters from a small alphabet so that matches are common.
   function automatic logic [BYTE_BITS-1:0] text_letter();
      if ($urandom_range(0, 19) == 0) return BYTE_BITS'($urandom_range(0, 255));
      return LETTER_A + BYTE_BITS'($urandom_range(0, 2));
   endfunction

   // Offers one item at a falling edge and holds it until it is taken.
   task automatic send_item(input logic [BYTE_BITS-1:0] b, input logic fs);
      int unsigned gap;
      gap = steady_line ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_text_byte  <= b;
      req_file_start <= fs;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input string s, input logic fs);
      for (int i = 0; i < s.len(); i++) send_item(s[i], fs && (i == 0));
   endtask

   // Line byte; a rare file start may land in the middle of a line.
   task automatic emit(input logic [BYTE_BITS-1:0] b);
      send_item(b, next_fs || ($urandom_range(0, 149) == 0));
      next_fs = 1'b0;
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [WORD_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Stop offering bytes and wait until every pending line result is out.
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (hits_waiting != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Writes pat_bytes and the two size registers, raw words as given.
   task automatic configure(input logic [WORD_BITS-1:0] len_word,
                            input logic [WORD_BITS-1:0] max_word);
      logic [WORD_BITS-1:0] words[PATTERN_WORDS];
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         words[i/8][(i%8)*BYTE_BITS +: BYTE_BITS] = pat_bytes[i];
      end
      csr_write(REG_PATTERN_0, words[0]);
      csr_write(REG_PATTERN_1, words[1]);
      csr_write(REG_PATTERN_2, words[2]);
      csr_write(REG_PATTERN_3, words[3]);
      csr_write(REG_PATTERN_LENGTH, len_word);
      csr_write(REG_MAX_LINE, max_word);
      pat_use = (len_word[LENGTH_BITS-1:0] > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES
                                                                : len_word[LENGTH_BITS-1:0];
   endtask

   // A line built from whole copies of the pattern, broken prefixes, letters
   // and noise, normally closed by a newline.
   task automatic send_line();
      int unsigned segs;
      int unsigned kind;
      int unsigned cut;
      steady_line = ($urandom_range(0, 7) == 0);
      next_fs     = ($urandom_range(0, 9) == 0);
      segs        = $urandom_range(0, 4);
      repeat (segs) begin
         kind = $urandom_range(0, 9);
         if (kind <= 3 && pat_use > 0) begin
            for (int i = 0; i < pat_use; i++) emit(pat_bytes[i]);
         end else if (kind <= 5 && pat_use > 0) begin
            cut = $urandom_range(1, pat_use);
            for (int i = 0; i < cut; i++) emit(pat_bytes[i]);
         end else if (kind <= 8) begin
            repeat ($urandom_range(1, 4)) emit(text_letter());
         end else begin
            emit(BYTE_BITS'($urandom_range(0, 255)));
         end
      end
      if ($urandom_range(0, 99) < 92) emit(NEWLINE_BYTE);
      steady_line = 1'b0;
   endtask

   initial begin
      int unsigned          budget;
      int unsigned          start_count;
      logic [LENGTH_BITS-1:0]   len_field;
      logic [LINE_LEN_BITS-1:0] max_field;
      logic [WORD_BITS-1:0]     junk;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_text_byte  = '0;
      req_file_start = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      steady_line    = 1'b0;
      next_fs        = 1'b0;
      bytes_sent     = 0;
      idle_cycles    = 0;
      pat_use        = 1;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Reset pattern is a single zero byte, which can never match.
      send_item(LETTER_A, 1'b1);
      send_item(ZERO_BYTE, 1'b0);
      send_item(NEWLINE_BYTE, 1'b0);
      drain();

      // Directed lines with the pattern "ab".
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         pat_bytes[i] = BYTE_BITS'($urandom_range(0, 255));
      end
      pat_bytes[0] = LETTER_A;
      pat_bytes[1] = LETTER_B;
      configure(64'd2, 64'd1024);
      send_text("abab\n", 1'b1);
      send_text("aab\n", 1'b0);
      send_text("ab", 1'b0);
      send_item(ZERO_BYTE, 1'b0);
      send_text("ab\n", 1'b0);
      send_text("\n", 1'b0);
      send_item(8'hFF, 1'b0);
      send_text("ab\n", 1'b0);
      send_text("ab\n", 1'b1);
      drain();

      // Random phases, the first ones pinned to the register extremes.
      for (int ph = 0; ph < 11; ph++) begin
         len_field = ($urandom_range(0, 9) < 7) ? LENGTH_BITS'($urandom_range(1, 4))
                                                : LENGTH_BITS'($urandom_range(5, 12));
         case ($urandom_range(0, 9))
            0, 1, 2: max_field = LINE_LEN_BITS'($urandom_range(4, 20));
            3:       max_field = DEFAULT_MAX_LINE;
            default: max_field = LINE_LEN_BITS'($urandom_range(100, 2000));
         endcase
         budget = 90;
         case (ph)
            0: begin
               len_field = '0;
               max_field = DEFAULT_MAX_LINE;
            end
            1: begin
               len_field = LENGTH_BITS'(MAX_PATTERN_BYTES);
               max_field = DEFAULT_MAX_LINE;
            end
            2: begin
               len_field = LENGTH_BITS'($urandom_range(MAX_PATTERN_BYTES + 1, 63));
               max_field = DEFAULT_MAX_LINE;
            end
            3: begin
               len_field = '1;
               max_field = '1;
            end
            4: begin
               max_field = '0;
               budget    = 30;
            end
            5: begin
               len_field = LENGTH_BITS'(1);
               max_field = LINE_LEN_BITS'(1);
               budget    = 30;
            end
            default: begin
            end
         endcase
         for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
            if (i < len_field) begin
               pat_bytes[i] = ($urandom_range(0, 9) == 0) ? BYTE_BITS'($urandom_range(1, 255))
                                                          : text_letter();
            end else begin
               pat_bytes[i] = BYTE_BITS'($urandom_range(0, 255));
            end
         end
         junk = $urandom_range(0, 1) ? {$urandom(), $urandom()} : '0;
         if (ph == 0) begin
            // Indexes past the last register are written once as well.
            csr_write(SPARE_INDEX_6, {$urandom(), $urandom()});
            csr_write(SPARE_INDEX_7, {$urandom(), $urandom()});
         end
         configure({junk[WORD_BITS-1:LENGTH_BITS], len_field},
                   {~junk[WORD_BITS-1:LINE_LEN_BITS], max_field});
         start_count = bytes_sent;
         while (bytes_sent - start_count < budget) begin
            send_line();
            // Now and then the sender holds off until all results are out.
            if ($urandom_range(0, 29) == 0) drain();
         end
         drain();
      end

      if (mismatch_count == 0 && hits_waiting == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
